// ===== sv/combined_lcg_shuffle_rng_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the combined LCG shuffle RNG unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_UNIT_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_UNIT_MACROS_SVH

// same-cycle implication
`define CLSR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clsr assertion failed");

// next-cycle implication
`define CLSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clsr assertion failed");

`endif

// ===== sv/clsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants, types and control structs shared by the RNG controller and
// datapath.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned SlotW      = $clog2(TableDepth);
  localparam int unsigned WarmExtra  = 8;
  localparam int unsigned WarmSteps  = TableDepth + WarmExtra;
  localparam int unsigned WarmW      = $clog2(WarmSteps);

  localparam int unsigned GenW  = 31;
  localparam int unsigned MulW  = 16;
  localparam int unsigned ProdW = GenW + MulW;
  localparam int unsigned FoldW = 8;

  localparam logic [GenW-1:0] ModA = 31'd2147483563;
  localparam logic [GenW-1:0] ModB = 31'd2147483399;
  localparam logic [MulW-1:0] MulA = 16'd40014;
  localparam logic [MulW-1:0] MulB = 16'd40692;
  // 2^31 mod ModA and 2^31 mod ModB
  localparam logic [FoldW-1:0] FoldA = 8'd85;
  localparam logic [FoldW-1:0] FoldB = 8'd249;

  localparam int unsigned TopOutInt  = 32'd2147483562;
  localparam int unsigned SlotDivInt = 1 + TopOutInt / TableDepth;
  localparam logic [GenW-1:0] TopOut  = GenW'(TopOutInt);
  localparam logic [GenW-1:0] SlotDiv = GenW'(SlotDivInt);

  localparam logic [GenW-1:0] SeedAReset = 31'd1;
  localparam logic [GenW-1:0] SeedBReset = 31'd123456789;

  typedef enum logic {
    KIND_DRAW = 1'b0,
    KIND_SEED = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_RED,
    ST_DRAW_RED,
    ST_DRAW_READ,
    ST_DRAW_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic seed_load;
    logic warm_step;
    logic draw_red;
    logic mem_read;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic warm_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/clsr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_ctrl
// Sequencer for the RNG: reseed warm-up loop and the draw sequence.
// ----------------------------------------------------------------------------
module clsr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  output logic                  in_ready_o,
  input  clsr_pkg::dp_status_t  status_i,
  output clsr_pkg::dp_cmd_t     cmd_o
);

  clsr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      clsr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (kind_i == clsr_pkg::KIND_SEED) begin
            cmd_o.seed_load = 1'b1;
            state_d         = clsr_pkg::ST_SEED_MUL;
          end else begin
            state_d = clsr_pkg::ST_DRAW_RED;
          end
        end
      end
      clsr_pkg::ST_SEED_MUL: begin
        state_d = clsr_pkg::ST_SEED_RED;
      end
      clsr_pkg::ST_SEED_RED: begin
        cmd_o.warm_step = 1'b1;
        state_d = status_i.warm_last ? clsr_pkg::ST_IDLE : clsr_pkg::ST_SEED_MUL;
      end
      clsr_pkg::ST_DRAW_RED: begin
        cmd_o.draw_red = 1'b1;
        state_d        = clsr_pkg::ST_DRAW_READ;
      end
      clsr_pkg::ST_DRAW_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = clsr_pkg::ST_DRAW_OUT;
      end
      clsr_pkg::ST_DRAW_OUT: begin
        // wait for a free output register
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = clsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = clsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/clsr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_dp
// Datapath: both generators with constant-modulus reduction, slot select by
// constant compares, shuffle table memory and the output register.
// ----------------------------------------------------------------------------
module clsr_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [clsr_pkg::GenW-1:0]    seed_value_i,
  input  clsr_pkg::dp_cmd_t            cmd_i,
  output clsr_pkg::dp_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [clsr_pkg::GenW-1:0]    random_value_o
);

  localparam int unsigned GenW  = clsr_pkg::GenW;
  localparam int unsigned ProdW = clsr_pkg::ProdW;
  localparam int unsigned SlotW = clsr_pkg::SlotW;
  localparam int unsigned WarmW = clsr_pkg::WarmW;
  localparam int unsigned Depth = clsr_pkg::TableDepth;

  // x*m mod p with p = 2^31 - f: fold the high part back in, then one subtract
  function automatic logic [GenW-1:0] mod_fold(
    input logic [ProdW-1:0]          prod,
    input logic [GenW-1:0]           modulus,
    input logic [clsr_pkg::FoldW-1:0] fold
  );
    logic [GenW:0] sum;
    sum = {1'b0, prod[GenW-1:0]}
        + ((GenW+1)'(prod[ProdW-1:GenW]) * (GenW+1)'(fold));
    if (sum >= {1'b0, modulus}) begin
      sum = sum - {1'b0, modulus};
    end
    return sum[GenW-1:0];
  endfunction

  logic [GenW-1:0]  fa_q, fb_q, last_q;
  logic [ProdW-1:0] prod_a_q, prod_b_q;
  logic [GenW-1:0]  red_a, red_b;
  logic [GenW-1:0]  seed_eff;

  logic [SlotW-1:0] slot;

  logic [WarmW-1:0] warm_cnt_q;
  logic             warm_in_table;

  logic [GenW-1:0]  mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [GenW-1:0]  rd_raw_q;
  logic             rd_vld_q;
  logic [GenW-1:0]  rd_data;
  logic             mem_we;
  logic [SlotW-1:0] mem_wa;
  logic [GenW-1:0]  mem_wd;

  logic [GenW:0]    diff, wrap;
  logic [GenW-1:0]  y;

  logic             out_valid_q;
  logic [GenW-1:0]  out_data_q;

  // products are free-running; the sequencer reads them only once they are registered from settled fa/fb
  always_ff @(posedge clk_i) begin
    prod_a_q <= ProdW'(fa_q) * ProdW'(clsr_pkg::MulA);
    prod_b_q <= ProdW'(fb_q) * ProdW'(clsr_pkg::MulB);
  end

  assign red_a    = mod_fold(prod_a_q, clsr_pkg::ModA, clsr_pkg::FoldA);
  assign red_b    = mod_fold(prod_b_q, clsr_pkg::ModB, clsr_pkg::FoldB);
  assign seed_eff = (seed_value_i == '0) ? GenW'(1) : seed_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fa_q <= clsr_pkg::SeedAReset;
      fb_q <= clsr_pkg::SeedBReset;
    end else if (cmd_i.seed_load) begin
      fa_q <= seed_eff;
      fb_q <= seed_eff;
    end else if (cmd_i.warm_step) begin
      fa_q <= red_a;
    end else if (cmd_i.draw_red) begin
      fa_q <= red_a;
      fb_q <= red_b;
    end
  end

  // warm-up counter: counts down, the last Depth values land in the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_cnt_q <= '0;
    end else if (cmd_i.seed_load) begin
      warm_cnt_q <= WarmW'(clsr_pkg::WarmSteps - 1);
    end else if (cmd_i.warm_step) begin
      warm_cnt_q <= warm_cnt_q - WarmW'(1);
    end
  end

  assign warm_in_table = (warm_cnt_q < WarmW'(Depth));

  // slot = last output / SlotDiv: count the constant multiples it reaches;
  // the highest threshold caps the slot at Depth-1
  always_comb begin
    slot = '0;
    for (int unsigned k = 1; k < Depth; k++) begin
      if ({1'b0, last_q} >= (GenW+1)'(k * clsr_pkg::SlotDivInt)) begin
        slot = SlotW'(k);
      end
    end
  end

  // shuffle table
  assign mem_we = (cmd_i.warm_step && warm_in_table) || cmd_i.commit;
  assign mem_wa = cmd_i.commit ? slot : warm_cnt_q[SlotW-1:0];
  assign mem_wd = cmd_i.commit ? fa_q : red_a;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.mem_read) begin
      rd_raw_q <= mem[slot];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (cmd_i.mem_read) begin
        rd_vld_q <= vld_q[slot];
      end
    end
  end

  assign rd_data = rd_vld_q ? rd_raw_q : '0;

  // y = entry - second_gen, wrapped into 1..TopOut when not positive
  assign diff = {1'b0, rd_data} - {1'b0, fb_q};
  assign wrap = diff + {1'b0, clsr_pkg::TopOut};
  assign y    = (diff[GenW] || (diff == '0)) ? wrap[GenW-1:0] : diff[GenW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (cmd_i.warm_step && (warm_cnt_q == '0)) begin
      last_q <= red_a;
    end else if (cmd_i.commit) begin
      last_q <= y;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= y;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign random_value_o = out_data_q;

  assign status_o.warm_last = (warm_cnt_q == '0);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== sv/combined_lcg_shuffle_rng_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng_unit
// Combined two-modulus multiplicative generator with a 32-entry shuffle
// table. kind=0 draws one value in 1..2147483562; kind=1 reseeds and gives
// no result. One item is in flight at a time. A draw steps both generators,
// then does a registered table read at the slot picked from the previous
// output by a bank of constant compares, then commits the value to the
// output register, waiting while that register is still held. A reseed
// runs 40 warm-up steps of the first generator, each passing through the
// 16x31 multiplier and then the fold-and-subtract reduction. Draws before
// any reseed run from the reset state with an all-zero table.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic [clsr_pkg::GenW-1:0]  seed_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [clsr_pkg::GenW-1:0]  random_value_o
);

  clsr_pkg::dp_cmd_t    cmd;
  clsr_pkg::dp_status_t status;

  clsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clsr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .seed_value_i   (seed_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o)
  );

endmodule

// ===== sv/clsr_sva.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsr_sva
// Port-level checks for the RNG unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_unit_macros.svh"

module clsr_sva (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [clsr_pkg::GenW-1:0] random_value_o
);

  // every delivered value lies in 1..TopOut
  `CLSR_ASSERT_IMPL(a_out_range, out_valid_o, (random_value_o != '0) && (random_value_o <= clsr_pkg::TopOut))

  // a stalled beat holds
  `CLSR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(random_value_o))

  // one item in flight: busy right after an accept
  `CLSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // no result can appear the cycle after an accept
  `CLSR_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_o, !$rose(out_valid_o))

endmodule

bind combined_lcg_shuffle_rng_unit clsr_sva u_clsr_sva (.*);

// ===== test/tb_combined_lcg_shuffle_rng_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_combined_lcg_shuffle_rng_unit
// Self-checking bench for the combined LCG / shuffle-table RNG. Reseed and
// draw beats go in over a valid/ready port. A scoreboard keeps its own copy
// of both generators, the last output and the shuffle table. It predicts
// every draw and compares it with the beats that come out. Both ports idle at
// random, and one long output stall lets the unit back up its input.
// ----------------------------------------------------------------------------
module tb_combined_lcg_shuffle_rng_unit;

  localparam int unsigned GenW       = clsr_pkg::GenW;
  localparam int unsigned TableDepth = clsr_pkg::TableDepth;

  localparam int unsigned RandBeats   = 1825;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned HoldCycles  = 400;
  localparam longint unsigned CycleLimit = 600000;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the generator state, queue of predicted draws
  // --------------------------------------------------------------------------
  class rng_scoreboard;
    longint unsigned gen_a;
    longint unsigned gen_b;
    longint unsigned prev_out;
    longint unsigned shuf_mem [TableDepth];
    logic [GenW-1:0] draw_q [$];
    int unsigned     fault_cnt;

    function new();
      gen_a    = longint'(clsr_pkg::SeedAReset);
      gen_b    = longint'(clsr_pkg::SeedBReset);
      prev_out = 0;
      foreach (shuf_mem[i]) shuf_mem[i] = 0;
      fault_cnt = 0;
    endfunction

    function longint unsigned mul_mod_a(longint unsigned x);
      return (longint'(clsr_pkg::MulA) * x) % longint'(clsr_pkg::ModA);
    endfunction

    function longint unsigned mul_mod_b(longint unsigned x);
      return (longint'(clsr_pkg::MulB) * x) % longint'(clsr_pkg::ModB);
    endfunction

    // called for every accepted input beat
    function void note_beat(clsr_pkg::kind_e kind, logic [GenW-1:0] seed);
      longint unsigned slot;
      longint          diff;
      if (kind == clsr_pkg::KIND_SEED) begin
        gen_a = (seed == '0) ? 1 : longint'(seed);
        gen_b = gen_a;
        for (int n = TableDepth + clsr_pkg::WarmExtra - 1; n >= 0; n--) begin
          gen_a = mul_mod_a(gen_a);
          if (n < TableDepth) shuf_mem[n] = gen_a;
        end
        prev_out = shuf_mem[0];
      end else begin
        gen_a = mul_mod_a(gen_a);
        gen_b = mul_mod_b(gen_b);
        slot  = prev_out / longint'(clsr_pkg::SlotDiv);
        if (slot >= TableDepth) slot = TableDepth - 1;
        diff = longint'(shuf_mem[slot]) - longint'(gen_b);
        shuf_mem[slot] = gen_a;
        if (diff < 1) diff += longint'(clsr_pkg::TopOut);
        prev_out = diff & 64'h7FFF_FFFF;
        draw_q.push_back(GenW'(prev_out));
      end
    endfunction

    // called for every accepted output beat
    function void check_beat(logic [GenW-1:0] got);
      logic [GenW-1:0] want;
      if (draw_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("[%0t] unexpected output beat: random_value=%0d", $realtime, got);
        return;
      end
      want = draw_q.pop_front();
      if (got !== want) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("[%0t] random_value mismatch: expected %0d, got %0d",
                   $realtime, want, got);
      end
    endfunction

    function int unsigned pending();
      return draw_q.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  logic            kind_i;
  logic [GenW-1:0] seed_value_i;
  logic            out_valid_o;
  logic            out_ready_i;
  logic [GenW-1:0] random_value_o;

  rng_scoreboard   sb = new();
  int unsigned     beats_in;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  bit              hold_req;
  longint unsigned cycle_cnt;

  combined_lcg_shuffle_rng_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .seed_value_i   (seed_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .random_value_o (random_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // monitor: both ports sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_beat(clsr_pkg::kind_e'(kind_i), seed_value_i);
        beats_in++;
      end
      if (out_valid_o && out_ready_i) sb.check_beat(random_value_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // output side: random back-pressure, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned idle_pct;
    bit          start_hold;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      idle_pct   = rx_idle_pct;
      start_hold = hold_req;
      @(negedge clk_i);
      if (start_hold && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (!rst_ni) begin
        out_ready_i = 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken, with valid still high so back-to-back beats need no re-raise.
  task automatic send_beat(clsr_pkg::kind_e kind, logic [GenW-1:0] seed);
    int unsigned target;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    kind_i       = kind;
    seed_value_i = seed;
    target       = beats_in + 1;
    while (beats_in < target) @(negedge clk_i);
  endtask

  function automatic logic [GenW-1:0] pick_seed();
    case ($urandom_range(9))
      0:       return '0;
      1:       return clsr_pkg::ModA;
      2:       return clsr_pkg::ModB;
      3:       return '1;
      4:       return clsr_pkg::ModA - GenW'($urandom_range(3));
      default: return GenW'($urandom());
    endcase
  endfunction

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    kind_i       = clsr_pkg::KIND_DRAW;
    seed_value_i = '0;
    beats_in     = 0;
    cycle_cnt    = 0;
    hold_req     = 1'b0;
    tx_idle_pct  = 20;
    rx_idle_pct  = 54;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // draws straight out of reset, all-zero table
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_DRAW, '1);
    send_beat(clsr_pkg::KIND_DRAW, 31'h2AAA_AAAA);
    // zero seed behaves as one
    send_beat(clsr_pkg::KIND_SEED, '0);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_SEED, 31'd1);
    send_beat(clsr_pkg::KIND_DRAW, 31'h5555_5555);
    // seeds above the moduli
    send_beat(clsr_pkg::KIND_SEED, '1);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    // first generator locks at zero
    send_beat(clsr_pkg::KIND_SEED, clsr_pkg::ModA);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_DRAW, '1);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    // second generator locks at zero
    send_beat(clsr_pkg::KIND_SEED, clsr_pkg::ModB);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_SEED, clsr_pkg::TopOut);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_SEED, 31'h5555_5555);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_SEED, 31'h2AAA_AAAA);
    send_beat(clsr_pkg::KIND_DRAW, '0);
    send_beat(clsr_pkg::KIND_DRAW, '0);

    for (int unsigned i = 0; i < RandBeats; i++) begin
      if (i == RandBeats / 3) begin
        tx_idle_pct = 54;
        rx_idle_pct = 20;
      end
      if (i == 2 * RandBeats / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    = 1'b1;
      end
      if ($urandom_range(99) < 8) send_beat(clsr_pkg::KIND_SEED, pick_seed());
      else                        send_beat(clsr_pkg::KIND_DRAW, GenW'($urandom()));
    end
    in_valid_i = 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    // a trailing reseed may still be running
    repeat (DrainCycles) @(negedge clk_i);

    if (sb.fault_cnt + sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== combined_lcg_shuffle_rng_unit.f =====
+incdir+sv
sv/clsr_pkg.sv
sv/clsr_ctrl.sv
sv/clsr_dp.sv
sv/combined_lcg_shuffle_rng_unit.sv
sv/clsr_sva.sv
test/tb_combined_lcg_shuffle_rng_unit.sv
